[design/ensc_pkg.sv]
// Shared types, constants and latencies of the environment sensor compensation core.
package ensc_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CALIB_TEMP   = 3'd0,
    REG_CALIB_PRES_A = 3'd1,
    REG_CALIB_PRES_B = 3'd2,
    REG_CALIB_PRES_C = 3'd3,
    REG_CALIB_HUM    = 3'd4
  } reg_idx_t;

  // Compensation constants
  localparam int unsigned PRS_TFINE_OFS = 128000;
  localparam int unsigned PRS_ADC_FULL  = 1048576;
  localparam int unsigned PRS_NUM_SCALE = 3125;
  localparam int unsigned HUM_TFINE_OFS = 76800;
  localparam int unsigned HUM_ROUND_X   = 16384;
  localparam int unsigned HUM_Y_OFS_A   = 32768;
  localparam int unsigned HUM_Y_OFS_B   = 2097152;
  localparam int unsigned HUM_ROUND_Y   = 8192;
  localparam int unsigned HUM_CLAMP     = 419430400;
  localparam int unsigned HUM_MAX_OUT   = HUM_CLAMP / 4096;

  // Divider: 64 quotient bits, divisor magnitude fits 31 bits
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_DEN_W = 31;

  // Stage counts of each unit
  localparam int unsigned TMP_LAT  = 5;
  localparam int unsigned HUM_LAT  = 11;
  localparam int unsigned PRS_LAT  = 7;
  localparam int unsigned DIV_LAT  = DIV_STEPS + 2;
  localparam int unsigned POST_LAT = 5;
  localparam int unsigned CORE_LAT = TMP_LAT + HUM_LAT + PRS_LAT + DIV_LAT + POST_LAT;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               result_valid;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] tcenti;
    logic signed [31:0] tfine;
    logic [19:0]        adc_p;
    logic [15:0]        adc_h;
  } tmp_res_t;

  typedef struct packed {
    logic signed [31:0] tcenti;
    logic signed [31:0] tfine;
    logic [19:0]        adc_p;
    logic [16:0]        hum;
  } hum_res_t;

  typedef struct packed {
    logic signed [31:0] tcenti;
    logic signed [31:0] tfine;
    logic [16:0]        hum;
    logic               den_zero;
  } div_side_t;

endpackage

[design/ensc_temp.sv]
// Temperature compensation pipeline: fine temperature and hundredths of a degree.
module ensc_temp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ensc_pkg::in_item_t in_item,
  input  logic [47:0]        calib_temp,
  output logic               out_valid,
  output ensc_pkg::tmp_res_t out_res
);
  localparam int unsigned NSTG = ensc_pkg::TMP_LAT;

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [NSTG-1:0]    vld_r;
  ensc_pkg::in_item_t raw_r [NSTG];

  logic signed [17:0] a_nxt, a_r;
  logic signed [16:0] b_nxt, b_r;
  logic signed [33:0] m1_nxt, m2_nxt;
  logic signed [31:0] m1_r, m2_r;
  logic signed [19:0] bb;
  logic signed [20:0] v1_nxt, v1_r;
  logic signed [35:0] m3_nxt;
  logic signed [31:0] m3_r;
  logic signed [17:0] v2;
  logic signed [31:0] tfine_nxt, tfine_r, tfine_d_r;
  logic signed [31:0] tc_sum, tcenti_nxt, tcenti_r;

  assign t1 = calib_temp[15:0];
  assign t2 = $signed(calib_temp[31:16]);
  assign t3 = $signed(calib_temp[47:32]);

  assign a_nxt = $signed({1'b0, in_item.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign b_nxt = $signed({1'b0, in_item.raw_temperature[19:4]}) - $signed({1'b0, t1});

  assign m1_nxt = a_r * t2;
  assign m2_nxt = b_r * b_r;

  assign v1_nxt = 21'(m1_r >>> 11);
  assign bb     = 20'(m2_r >>> 12);
  assign m3_nxt = bb * t3;

  assign v2        = 18'(m3_r >>> 14);
  assign tfine_nxt = 32'(v1_r) + 32'(v2);

  assign tc_sum     = (tfine_r <<< 2) + tfine_r + 32'sd128;
  assign tcenti_nxt = tc_sum >>> 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    raw_r[0] <= in_item;
    for (int k = 1; k < NSTG; k++) begin
      raw_r[k] <= raw_r[k-1];
    end
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    m1_r      <= m1_nxt[31:0];
    m2_r      <= m2_nxt[31:0];
    v1_r      <= v1_nxt;
    m3_r      <= m3_nxt[31:0];
    tfine_r   <= tfine_nxt;
    tcenti_r  <= tcenti_nxt;
    tfine_d_r <= tfine_r;
  end

  assign out_valid      = vld_r[NSTG-1];
  assign out_res.tcenti = tcenti_r;
  assign out_res.tfine  = tfine_d_r;
  assign out_res.adc_p  = raw_r[NSTG-1].raw_pressure;
  assign out_res.adc_h  = raw_r[NSTG-1].raw_humidity;

endmodule

[design/ensc_hum.sv]
// Humidity compensation pipeline in 32-bit wrapping arithmetic, clamped to 0..100 percent.
module ensc_hum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ensc_pkg::tmp_res_t in_res,
  input  logic [63:0]        calib_hum,
  output logic               out_valid,
  output ensc_pkg::hum_res_t out_res
);
  localparam int unsigned NSTG = ensc_pkg::HUM_LAT;
  localparam int unsigned XDLY = 5;

  logic [7:0]         h1, h3;
  logic signed [15:0] h2;
  logic [11:0]        h4;
  logic signed [11:0] h5;
  logic signed [7:0]  h6;

  logic [NSTG-1:0]    vld_r;
  ensc_pkg::tmp_res_t sd_r [NSTG];

  logic signed [31:0] hv_nxt, hv_r;
  logic signed [31:0] p5_nxt, p5_r, p6m_nxt, p6m_r, p3m_nxt, p3m_r, xpre_nxt, xpre_r;
  logic signed [16:0] x_nxt;
  logic signed [16:0] xd_r [XDLY];
  logic signed [21:0] ya_nxt, ya_r, yb_nxt, yb_r;
  logic signed [43:0] y1_full;
  logic signed [31:0] y1_r;
  logic signed [22:0] y2_nxt, y2_r;
  logic signed [38:0] y3_full;
  logic signed [31:0] y3_r;
  logic signed [17:0] y4_nxt, y4_r;
  logic signed [34:0] hv2_full;
  logic signed [31:0] hv2_r, hv2d_r, hv2dd_r;
  logic signed [16:0] s;
  logic signed [33:0] ss_full;
  logic signed [31:0] ss_r;
  logic signed [33:0] t_full;
  logic signed [31:0] t_r;
  logic signed [31:0] hv3;
  logic [16:0]        hum_nxt, hum_r;

  assign h1 = calib_hum[7:0];
  assign h2 = $signed(calib_hum[23:8]);
  assign h3 = calib_hum[31:24];
  assign h4 = calib_hum[43:32];
  assign h5 = $signed(calib_hum[55:44]);
  assign h6 = $signed(calib_hum[63:56]);

  assign hv_nxt = in_res.tfine - 32'(ensc_pkg::HUM_TFINE_OFS);

  assign p5_nxt   = hv_r * h5;
  assign p6m_nxt  = hv_r * h6;
  assign p3m_nxt  = hv_r * $signed({1'b0, h3});
  assign xpre_nxt = $signed({2'b00, sd_r[0].adc_h, 14'd0}) - $signed({h4, 20'd0})
                    + 32'(ensc_pkg::HUM_ROUND_X);

  assign x_nxt  = 17'((xpre_r - p5_r) >>> 15);
  assign ya_nxt = 22'(p6m_r >>> 10);
  assign yb_nxt = 22'(p3m_r >>> 11) + 22'(ensc_pkg::HUM_Y_OFS_A);

  assign y1_full = ya_r * yb_r;
  assign y2_nxt  = 23'(y1_r >>> 10) + 23'(ensc_pkg::HUM_Y_OFS_B);
  assign y3_full = y2_r * h2;
  assign y4_nxt  = 18'((y3_r + 32'(ensc_pkg::HUM_ROUND_Y)) >>> 14);
  assign hv2_full = xd_r[XDLY-1] * y4_r;

  assign s       = 17'(hv2_r >>> 15);
  assign ss_full = s * s;
  assign t_full  = 25'(ss_r >>> 7) * $signed({1'b0, h1});

  // clamp: negative reads as zero, above full scale limits to 100 percent
  assign hv3 = hv2dd_r - (t_r >>> 4);
  always_comb begin
    priority if (hv3[31]) begin
      hum_nxt = '0;
    end else if (hv3 > 32'(ensc_pkg::HUM_CLAMP)) begin
      hum_nxt = 17'(ensc_pkg::HUM_MAX_OUT);
    end else begin
      hum_nxt = hv3[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= in_res;
    for (int k = 1; k < NSTG; k++) begin
      sd_r[k] <= sd_r[k-1];
    end
    xd_r[0] <= x_nxt;
    for (int k = 1; k < XDLY; k++) begin
      xd_r[k] <= xd_r[k-1];
    end
    hv_r    <= hv_nxt;
    p5_r    <= p5_nxt;
    p6m_r   <= p6m_nxt;
    p3m_r   <= p3m_nxt;
    xpre_r  <= xpre_nxt;
    ya_r    <= ya_nxt;
    yb_r    <= yb_nxt;
    y1_r    <= y1_full[31:0];
    y2_r    <= y2_nxt;
    y3_r    <= y3_full[31:0];
    y4_r    <= y4_nxt;
    hv2_r   <= hv2_full[31:0];
    ss_r    <= ss_full[31:0];
    hv2d_r  <= hv2_r;
    t_r     <= t_full[31:0];
    hv2dd_r <= hv2d_r;
    hum_r   <= hum_nxt;
  end

  assign out_valid      = vld_r[NSTG-1];
  assign out_res.tcenti = sd_r[NSTG-1].tcenti;
  assign out_res.tfine  = sd_r[NSTG-1].tfine;
  assign out_res.adc_p  = sd_r[NSTG-1].adc_p;
  assign out_res.hum    = hum_r;

endmodule

[design/ensc_prs.sv]
// Pressure front end: builds the 64-bit dividend and the divisor in wrapping arithmetic.
module ensc_prs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ensc_pkg::hum_res_t  in_res,
  input  logic [63:0]         calib_pres_a,
  input  logic [63:0]         calib_pres_b,
  output logic                out_valid,
  output logic [63:0]         num,
  output logic signed [ensc_pkg::DIV_DEN_W-1:0] den,
  output ensc_pkg::div_side_t out_side
);
  localparam int unsigned NSTG = ensc_pkg::PRS_LAT;

  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6;

  logic [NSTG-1:0]    vld_r;
  ensc_pkg::hum_res_t sd_r [NSTG];

  logic signed [32:0] q1_nxt, q1_r;
  logic signed [65:0] qq_full;
  logic [63:0]        qq_r;
  logic signed [48:0] qp5_nxt, qp5_r, qp5d_r, qp2_nxt, qp2_r, qp2d_r;
  logic [63:0]        a6_nxt, a6_r, a3_nxt, a3_r;
  logic [63:0]        q2_nxt, q2_r, c1_nxt, c1_r;
  logic [20:0]        pf;
  logic [63:0]        e_nxt, e_r, n1_nxt, n1_r;
  logic [63:0]        d_nxt, d_r, num_nxt, num_r, num2_r;
  logic signed [ensc_pkg::DIV_DEN_W-1:0] den_nxt, den_r;
  logic               zero_nxt, zero_r;

  assign p1 = calib_pres_a[15:0];
  assign p2 = $signed(calib_pres_a[31:16]);
  assign p3 = $signed(calib_pres_a[47:32]);
  assign p4 = $signed(calib_pres_a[63:48]);
  assign p5 = $signed(calib_pres_b[15:0]);
  assign p6 = $signed(calib_pres_b[31:16]);

  assign q1_nxt = 33'(in_res.tfine) - 33'(ensc_pkg::PRS_TFINE_OFS);

  assign qq_full = q1_r * q1_r;
  assign qp5_nxt = q1_r * p5;
  assign qp2_nxt = q1_r * p2;

  assign a6_nxt = qq_r * 64'(p6);
  assign a3_nxt = qq_r * 64'(p3);

  assign q2_nxt = a6_r + (64'(qp5d_r) << 17) + (64'(p4) << 35);
  assign c1_nxt = 64'($signed(a3_r) >>> 8) + (64'(qp2d_r) << 12);

  assign pf     = 21'(ensc_pkg::PRS_ADC_FULL) - {1'b0, sd_r[3].adc_p};
  assign e_nxt  = c1_r + (64'd1 << 47);
  assign n1_nxt = {12'd0, pf, 31'd0} - q2_r;

  assign d_nxt   = e_r * {48'd0, p1};
  assign num_nxt = n1_r * 64'(ensc_pkg::PRS_NUM_SCALE);

  assign den_nxt  = ensc_pkg::DIV_DEN_W'($signed(d_r) >>> 33);
  assign zero_nxt = (d_r[63:33] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= in_res;
    for (int k = 1; k < NSTG; k++) begin
      sd_r[k] <= sd_r[k-1];
    end
    q1_r   <= q1_nxt;
    qq_r   <= qq_full[63:0];
    qp5_r  <= qp5_nxt;
    qp2_r  <= qp2_nxt;
    a6_r   <= a6_nxt;
    a3_r   <= a3_nxt;
    qp5d_r <= qp5_r;
    qp2d_r <= qp2_r;
    q2_r   <= q2_nxt;
    c1_r   <= c1_nxt;
    e_r    <= e_nxt;
    n1_r   <= n1_nxt;
    d_r    <= d_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    zero_r <= zero_nxt;
    num2_r <= num_r;
  end

  assign out_valid         = vld_r[NSTG-1];
  assign num               = num2_r;
  assign den               = den_r;
  assign out_side.tcenti   = sd_r[NSTG-1].tcenti;
  assign out_side.tfine    = sd_r[NSTG-1].tfine;
  assign out_side.hum      = sd_r[NSTG-1].hum;
  assign out_side.den_zero = zero_r;

endmodule

[design/ensc_div.sv]
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
module ensc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [63:0]         num,
  input  logic signed [ensc_pkg::DIV_DEN_W-1:0] den,
  input  ensc_pkg::div_side_t in_side,
  output logic                out_valid,
  output logic [63:0]         quot,
  output ensc_pkg::div_side_t out_side
);
  localparam int unsigned NSTEP = ensc_pkg::DIV_STEPS;
  localparam int unsigned NSTG  = ensc_pkg::DIV_LAT;
  localparam int unsigned DW    = ensc_pkg::DIV_DEN_W;

  logic [NSTG-1:0]     vld_r;
  ensc_pkg::div_side_t sd_r [NSTG];

  logic [63:0]   w_r  [NSTEP+1];
  logic [DW-1:0] rm_r [NSTEP+1];
  logic [DW-1:0] ad_r [NSTEP+1];
  logic          qn_r [NSTEP+1];

  logic [63:0]   an_nxt;
  logic [DW-1:0] ad_nxt;
  logic [63:0]   quot_nxt, quot_r;

  // take magnitudes; the most negative dividend maps onto itself as unsigned
  assign an_nxt = num[63] ? (64'd0 - num) : num;
  assign ad_nxt = den[DW-1] ? (DW'(0) - DW'(den)) : DW'(den);

  always_ff @(posedge clk) begin
    w_r[0]  <= an_nxt;
    rm_r[0] <= '0;
    ad_r[0] <= ad_nxt;
    qn_r[0] <= num[63] ^ den[DW-1];
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rm_r[k-1], w_r[k-1][63]} - {1'b0, ad_r[k-1]};
    assign ge    = ~trial[DW];
    always_ff @(posedge clk) begin
      rm_r[k] <= ge ? trial[DW-1:0] : {rm_r[k-1][DW-2:0], w_r[k-1][63]};
      w_r[k]  <= {w_r[k-1][62:0], ge};
      ad_r[k] <= ad_r[k-1];
      qn_r[k] <= qn_r[k-1];
    end
  end

  assign quot_nxt = qn_r[NSTEP] ? (64'd0 - w_r[NSTEP]) : w_r[NSTEP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= in_side;
    for (int k = 1; k < NSTG; k++) begin
      sd_r[k] <= sd_r[k-1];
    end
    quot_r <= quot_nxt;
  end

  assign out_valid = vld_r[NSTG-1];
  assign quot      = quot_r;
  assign out_side  = sd_r[NSTG-1];

endmodule

[design/ensc_post.sv]
// Pressure back end: second-order correction, offset and the output register.
module ensc_post (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [63:0]         quot,
  input  ensc_pkg::div_side_t in_side,
  input  logic [63:0]         calib_pres_b,
  input  logic [15:0]         calib_pres_c,
  output logic                out_valid,
  output ensc_pkg::out_item_t out_item
);
  localparam int unsigned NSTG = ensc_pkg::POST_LAT;

  logic signed [15:0] p7, p8, p9;

  logic [NSTG-1:0]     vld_r;
  ensc_pkg::div_side_t sd_r [NSTG-1];

  logic signed [50:0] s13_nxt, s13_r;
  logic signed [66:0] m9_full;
  logic [63:0]        m9_r, r2m_nxt, r2m_r, pf1_r, pf2_r, pf3_r;
  logic [63:0]        bsx;
  logic [63:0]        ll_nxt, ll_r;
  logic [31:0]        lh_nxt, lh_r, hl_nxt, hl_r;
  logic [63:0]        r2_nxt, r2_r, r2d_r;
  logic [63:0]        r1raw_nxt, r1raw_r;
  logic [63:0]        sum_nxt, sum_r;
  logic [31:0]        pres;
  ensc_pkg::out_item_t item_nxt, item_r;

  assign p7 = $signed(calib_pres_b[47:32]);
  assign p8 = $signed(calib_pres_b[63:48]);
  assign p9 = $signed(calib_pres_c);

  assign s13_nxt = 51'($signed(quot) >>> 13);
  assign m9_full = p9 * s13_nxt;
  assign r2m_nxt = quot * 64'(p8);

  // low 64 bits of the square term from three 32x32 partial products
  assign bsx    = 64'(s13_r);
  assign ll_nxt = {32'd0, m9_r[31:0]} * {32'd0, bsx[31:0]};
  assign lh_nxt = 32'(m9_r[31:0] * bsx[63:32]);
  assign hl_nxt = 32'(m9_r[63:32] * bsx[31:0]);
  assign r2_nxt = 64'($signed(r2m_r) >>> 19);

  assign r1raw_nxt = ll_r + {lh_r + hl_r, 32'd0};

  assign sum_nxt = pf3_r + 64'($signed(r1raw_r) >>> 25) + r2d_r;

  assign pres = sum_r[39:8] + {{12{p7[15]}}, p7, 4'd0};

  // zero divisor: drop pressure and humidity, flag the result
  always_comb begin
    item_nxt.temperature_centi = sd_r[NSTG-2].tcenti;
    item_nxt.fine_temperature  = sd_r[NSTG-2].tfine;
    item_nxt.result_valid      = ~sd_r[NSTG-2].den_zero;
    if (sd_r[NSTG-2].den_zero) begin
      item_nxt.pressure_q24_8  = '0;
      item_nxt.humidity_q22_10 = '0;
    end else begin
      item_nxt.pressure_q24_8  = pres;
      item_nxt.humidity_q22_10 = sd_r[NSTG-2].hum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= in_side;
    for (int k = 1; k < NSTG-1; k++) begin
      sd_r[k] <= sd_r[k-1];
    end
    s13_r   <= s13_nxt;
    m9_r    <= m9_full[63:0];
    r2m_r   <= r2m_nxt;
    pf1_r   <= quot;
    ll_r    <= ll_nxt;
    lh_r    <= lh_nxt;
    hl_r    <= hl_nxt;
    r2_r    <= r2_nxt;
    pf2_r   <= pf1_r;
    r1raw_r <= r1raw_nxt;
    r2d_r   <= r2_r;
    pf3_r   <= pf2_r;
    sum_r   <= sum_nxt;
    item_r  <= item_nxt;
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_item  = item_r;

endmodule

[design/environment_sensor_compensation_core.sv]
// Top level of the environment sensor compensation core: calibration registers and pipeline.
//
//   channel  | ports                                   | transfer when
//   ---------+-----------------------------------------+----------------------------
//   input    | start, busy, in_item                    | start high, busy low
//   result   | out_strobe, out_item                    | every cycle out_strobe is high
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid and cfg_ready high
//
// One sample enters per clock while busy is low; results leave in the order their
// samples were taken. The 66-stage divider (a magnitude stage, 64 stages of one
// quotient bit each, a sign stage) makes up most of the pipeline; temperature,
// humidity and the pressure terms use 5 + 11 + 7 stages before it and 5 after it.
// rst_n is synchronous and active low: it clears the calibration words and
// every stage valid bit; busy is high only while rst_n is low.
// The result side has no backpressure, so nothing in the pipeline ever holds.
module environment_sensor_compensation_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ensc_pkg::in_item_t             in_item,
  output logic                           out_strobe,
  output ensc_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ensc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ensc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [47:0] calib_temp_r;
  logic [63:0] calib_pres_a_r;
  logic [63:0] calib_pres_b_r;
  logic [15:0] calib_pres_c_r;
  logic [63:0] calib_hum_r;

  logic                in_take;
  logic                tmp_vld, hum_vld, prs_vld, div_vld;
  ensc_pkg::tmp_res_t  tmp_res;
  ensc_pkg::hum_res_t  hum_res;
  logic [63:0]         prs_num;
  logic signed [ensc_pkg::DIV_DEN_W-1:0] prs_den;
  ensc_pkg::div_side_t prs_side, div_side;
  logic [63:0]         div_quot;

  // hold off samples only while in reset
  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign in_take   = start & ~busy;

  // calibration words; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_temp_r   <= '0;
      calib_pres_a_r <= '0;
      calib_pres_b_r <= '0;
      calib_pres_c_r <= '0;
      calib_hum_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ensc_pkg::REG_CALIB_TEMP:   calib_temp_r   <= cfg_data[47:0];
        ensc_pkg::REG_CALIB_PRES_A: calib_pres_a_r <= cfg_data;
        ensc_pkg::REG_CALIB_PRES_B: calib_pres_b_r <= cfg_data;
        ensc_pkg::REG_CALIB_PRES_C: calib_pres_c_r <= cfg_data[15:0];
        ensc_pkg::REG_CALIB_HUM:    calib_hum_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // temperature first: every later term depends on the fine temperature
  ensc_temp u_temp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_take),
    .in_item    (in_item),
    .calib_temp (calib_temp_r),
    .out_valid  (tmp_vld),
    .out_res    (tmp_res)
  );

  // humidity runs ahead of pressure so its 17-bit result rides through the divider as side data
  ensc_hum u_hum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tmp_vld),
    .in_res    (tmp_res),
    .calib_hum (calib_hum_r),
    .out_valid (hum_vld),
    .out_res   (hum_res)
  );

  ensc_prs u_prs (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (hum_vld),
    .in_res       (hum_res),
    .calib_pres_a (calib_pres_a_r),
    .calib_pres_b (calib_pres_b_r),
    .out_valid    (prs_vld),
    .num          (prs_num),
    .den          (prs_den),
    .out_side     (prs_side)
  );

  ensc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prs_vld),
    .num       (prs_num),
    .den       (prs_den),
    .in_side   (prs_side),
    .out_valid (div_vld),
    .quot      (div_quot),
    .out_side  (div_side)
  );

  // final correction, zero-divisor masking and the output register
  ensc_post u_post (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (div_vld),
    .quot         (div_quot),
    .in_side      (div_side),
    .calib_pres_b (calib_pres_b_r),
    .calib_pres_c (calib_pres_c_r),
    .out_valid    (out_strobe),
    .out_item     (out_item)
  );

endmodule

[design/ensc_chk.sv]
// Port-level checker for the compensation core, bound to the top level.
module ensc_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input ensc_pkg::out_item_t             out_item
);

  logic signed [31:0] tc_sum;
  logic signed [31:0] tc_exp;

  assign tc_sum = (out_item.fine_temperature <<< 2) + out_item.fine_temperature + 32'sd128;
  assign tc_exp = tc_sum >>> 8;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == $past(start && !busy, ensc_pkg::CORE_LAT))
    else $error("result strobe does not match an accepted sample");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.result_valid) |->
      (out_item.pressure_q24_8 == '0 && out_item.humidity_q22_10 == '0))
    else $error("flagged result carries pressure or humidity");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.humidity_q22_10 <= 17'(ensc_pkg::HUM_MAX_OUT)))
    else $error("humidity above full scale");

  a_temp_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.temperature_centi == tc_exp))
    else $error("temperature does not follow fine temperature");

endmodule

bind environment_sensor_compensation_core ensc_chk u_ensc_chk (.*);

[dv/environment_sensor_compensation_core_tb.sv]
// Self-checking testbench of the environment sensor compensation core.
module environment_sensor_compensation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the last register; the core must ignore writes to it.
  localparam logic [ensc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;
  localparam int unsigned PHASE_ITEMS = 270;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ensc_pkg::in_item_t in_item = '0;
  logic out_strobe;
  ensc_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ensc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ensc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Calibration words as the core should hold them.
  logic [47:0] cal_temp   = '0;
  logic [63:0] cal_pres_a = '0;
  logic [63:0] cal_pres_b = '0;
  logic [15:0] cal_pres_c = '0;
  logic [63:0] cal_hum    = '0;

  ensc_pkg::in_item_t  sample_q[$];
  ensc_pkg::out_item_t comp_q[$];
  int unsigned fail_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned gap_pct  = 10;

  environment_sensor_compensation_core u_dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_strobe, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] asr32(logic [31:0] x, int s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  // Signed 64-bit quotient, truncated toward zero; wraps for min / -1.
  function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
    logic [63:0] an, ad, q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q  = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  // Compensate one raw sample with the current calibration.
  function automatic ensc_pkg::out_item_t compensate(ensc_pkg::in_item_t s);
    logic [31:0] t1, t2, t3, a, b, v1, v2, tfine;
    logic [31:0] h1, h2, h3, h4, h5, h6, hv, hx, hy, sq;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, q1, q2, pf, r1, r2;
    ensc_pkg::out_item_t r;
    t1 = {16'b0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {48'b0, cal_pres_a[15:0]};
    p2 = sx16(cal_pres_a[31:16]);
    p3 = sx16(cal_pres_a[47:32]);
    p4 = sx16(cal_pres_a[63:48]);
    p5 = sx16(cal_pres_b[15:0]);
    p6 = sx16(cal_pres_b[31:16]);
    p7 = sx16(cal_pres_b[47:32]);
    p8 = sx16(cal_pres_b[63:48]);
    p9 = sx16(cal_pres_c);
    h1 = {24'b0, cal_hum[7:0]};
    h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
    h3 = {24'b0, cal_hum[31:24]};
    h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
    h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
    h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};

    a  = ({12'b0, s.raw_temperature} >> 3) - (t1 << 1);
    v1 = asr32(a * t2, 11);
    b  = ({12'b0, s.raw_temperature} >> 4) - t1;
    v2 = asr32(asr32(b * b, 12) * t3, 14);
    tfine = v1 + v2;
    r.temperature_centi = asr32(tfine * 32'd5 + 32'd128, 8);
    r.fine_temperature  = tfine;
    r.pressure_q24_8    = '0;
    r.humidity_q22_10   = '0;
    r.result_valid      = 1'b0;

    q1 = {{32{tfine[31]}}, tfine} - 64'(ensc_pkg::PRS_TFINE_OFS);
    q2 = q1 * q1 * p6;
    q2 = q2 + ((q1 * p5) << 17);
    q2 = q2 + (p4 << 35);
    q1 = asr64(q1 * q1 * p3, 8) + ((q1 * p2) << 12);
    q1 = asr64(((64'd1 << 47) + q1) * p1, 33);
    // A zero divisor leaves pressure and humidity at zero and drops valid.
    if (q1 != 64'd0) begin
      pf = 64'(ensc_pkg::PRS_ADC_FULL) - {44'b0, s.raw_pressure};
      pf = div_trunc(((pf << 31) - q2) * 64'(ensc_pkg::PRS_NUM_SCALE), q1);
      r1 = asr64(p9 * asr64(pf, 13) * asr64(pf, 13), 25);
      r2 = asr64(p8 * pf, 19);
      pf = asr64(pf + r1 + r2, 8) + (p7 << 4);
      r.pressure_q24_8 = pf[31:0];

      hv = tfine - ensc_pkg::HUM_TFINE_OFS;
      hx = asr32(({16'b0, s.raw_humidity} << 14) - (h4 << 20) - h5 * hv
                 + ensc_pkg::HUM_ROUND_X, 15);
      hy = asr32(hv * h6, 10) * (asr32(hv * h3, 11) + ensc_pkg::HUM_Y_OFS_A);
      hy = (asr32(hy, 10) + ensc_pkg::HUM_Y_OFS_B) * h2 + ensc_pkg::HUM_ROUND_Y;
      hy = asr32(hy, 14);
      hv = hx * hy;
      sq = asr32(hv, 15);
      hv = hv - asr32(asr32(sq * sq, 7) * h1, 4);
      // Clamp to 0..100 percent.
      if (hv[31]) hv = '0;
      if (hv > ensc_pkg::HUM_CLAMP) hv = ensc_pkg::HUM_CLAMP;
      r.humidity_q22_10 = 17'(hv >> 12);
      r.result_valid = 1'b1;
    end
    return r;
  endfunction

  // Driver: present queued samples, record the prediction of each transfer,
  // and insert random idle bursts while gap_pct is nonzero.
  always @(posedge clk) begin
    logic nxt_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        comp_q.push_back(compensate(in_item));
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() != 0) begin
          in_item <= sample_q.pop_front();
          nxt_start = 1'b1;
          if ($urandom_range(99) < gap_pct) gap_left = $urandom_range(16, 1);
        end
      end
      start <= nxt_start;
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Monitor: every strobe carries one result; match it with the oldest prediction.
  always @(posedge clk) begin
    ensc_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (comp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $realtime, out_item);
        fail_cnt++;
      end else begin
        want = comp_q.pop_front();
        check_field("temperature_centi", want.temperature_centi, out_item.temperature_centi);
        check_field("fine_temperature", want.fine_temperature, out_item.fine_temperature);
        check_field("pressure_q24_8", want.pressure_q24_8, out_item.pressure_q24_8);
        check_field("humidity_q22_10", want.humidity_q22_10, out_item.humidity_q22_10);
        check_field("result_valid", want.result_valid, out_item.result_valid);
      end
    end
  end

  // Write one register; hold valid until the transfer, then update the shadow copy.
  task automatic write_reg(logic [ensc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ensc_pkg::REG_CALIB_TEMP:   cal_temp   = val[47:0];
      ensc_pkg::REG_CALIB_PRES_A: cal_pres_a = val;
      ensc_pkg::REG_CALIB_PRES_B: cal_pres_b = val;
      ensc_pkg::REG_CALIB_PRES_C: cal_pres_c = val[15:0];
      ensc_pkg::REG_CALIB_HUM:    cal_hum    = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                           logic [63:0] pc, logic [63:0] h);
    write_reg(ensc_pkg::REG_CALIB_TEMP, t);
    write_reg(ensc_pkg::REG_CALIB_PRES_A, pa);
    write_reg(ensc_pkg::REG_CALIB_PRES_B, pb);
    write_reg(ensc_pkg::REG_CALIB_PRES_C, pc);
    write_reg(ensc_pkg::REG_CALIB_HUM, h);
  endtask

  // Drain: hold until every sample is sent and every result checked, then let
  // the pipeline settle before touching the calibration.
  task automatic drain();
    while (sample_q.size() != 0 || start || comp_q.size() != 0) @(posedge clk);
    repeat (ensc_pkg::CORE_LAT + 8) @(posedge clk);
  endtask

  task automatic queue_sample(logic [19:0] p, logic [19:0] t, logic [15:0] h);
    ensc_pkg::in_item_t s;
    s.raw_pressure = p;
    s.raw_temperature = t;
    s.raw_humidity = h;
    sample_q.push_back(s);
  endtask

  // Mostly realistic readings around room conditions, some fully random.
  task automatic queue_random(int unsigned n);
    repeat (n) begin
      if ($urandom_range(3) != 0)
        queue_sample(20'(415148 + $urandom_range(120000) - 60000),
                     20'(519888 + $urandom_range(100000) - 50000),
                     16'(20000 + $urandom_range(30000)));
      else
        queue_sample(20'($urandom), 20'($urandom), 16'($urandom));
    end
  endtask

  localparam logic [63:0] TYP_TEMP   = {16'b0, -16'sd1000, 16'sd26435, 16'd27504};
  localparam logic [63:0] TYP_PRES_A = {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477};
  localparam logic [63:0] TYP_PRES_B = {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140};
  localparam logic [63:0] TYP_PRES_C = 64'd6000;
  localparam logic [63:0] TYP_HUM    = {8'sd30, 12'sd50, 12'sd313, 8'd0, 16'sd362, 8'd75};

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration: all zero, so the pressure divisor is zero.
    queue_sample(20'h00000, 20'h00000, 16'h0000);
    queue_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    queue_random(40);
    drain();

    // Typical calibration with the field extremes and clamp corners.
    write_all(TYP_TEMP, TYP_PRES_A, TYP_PRES_B, TYP_PRES_C, TYP_HUM);
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    queue_sample(20'h00000, 20'h00000, 16'h0000);
    queue_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    queue_sample(20'hFFFFF, 20'h00000, 16'hFFFF);
    queue_sample(20'h00000, 20'hFFFFF, 16'h0000);
    queue_sample(20'd415148, 20'd519888, 16'd30000);
    queue_sample(20'd415148, 20'd519888, 16'hFFFF);
    queue_sample(20'd415148, 20'd519888, 16'h0000);
    queue_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
    queue_sample(20'h55555, 20'hAAAAA, 16'h5555);
    queue_random(PHASE_ITEMS);
    drain();

    // All-ones calibration, then the most negative signed coefficients.
    write_all('1, '1, '1, '1, '1);
    queue_sample(20'h00000, 20'h00000, 16'h0000);
    queue_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    queue_random(200);
    drain();
    write_all(64'({16'h8000, 16'h8000, 16'hFFFF}),
              {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
              {4{16'h8000}}, 64'h8000, {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
    queue_random(150);
    drain();

    // Random calibration words, twice.
    repeat (2) begin
      write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                64'($urandom), {$urandom, $urandom});
      queue_random(PHASE_ITEMS);
      drain();
    end

    // Typical calibration once more, temperature and humidity words perturbed, without idle gaps to the end.
    write_all(TYP_TEMP ^ 64'($urandom_range(255)), TYP_PRES_A, TYP_PRES_B,
              TYP_PRES_C, TYP_HUM ^ {$urandom, $urandom});
    gap_pct = 0;
    queue_random(PHASE_ITEMS);
    drain();

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: the run is far shorter than this even with every idle burst.
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
